### src/qdec_pkg.sv
// ----------------------------------------------------------------------------
// qdec_pkg
// shared widths, constants, register indexes and types of the dual
// quadrature edge counter
// ----------------------------------------------------------------------------
package qdec_pkg;

  localparam int ACC_W      = 32;
  localparam int CNT_W      = 32;
  localparam int DELTA_W    = 16;
  localparam int SIGN_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIGN_W;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SIGN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SIGN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_ONLY  = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN   = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0] DELTA_MAX = 32'sd32767;
  localparam logic signed [ACC_W-1:0] DELTA_MIN = -32'sd32768;

  typedef struct packed {
    logic evt;
    logic a;
    logic b;
    logic take;
    logic restart;
  } side_ctrl_t;

endpackage

### src/qdec_side.sv
// ----------------------------------------------------------------------------
// qdec_side
// x1 (rise_only set) or x2 (rise_only clear) decoder of one encoder: saturating accumulator, event and ignored
// counters, next values of the reported fields
// ----------------------------------------------------------------------------
module qdec_side (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  commit,
  input  qdec_pkg::side_ctrl_t                  ctrl,
  input  logic                                  neg,
  input  logic                                  rise_only,
  output logic signed [qdec_pkg::DELTA_W-1:0]   delta,
  output logic        [qdec_pkg::CNT_W-1:0]     events_nxt,
  output logic        [qdec_pkg::CNT_W-1:0]     ignored_nxt
);

  logic signed [qdec_pkg::ACC_W-1:0] acc_r, acc_nxt, acc_upd;
  logic        [qdec_pkg::CNT_W-1:0] events_r, ignored_r;
  logic                              a_prev_r, a_prev_nxt;
  logic                              changed, count_edge, up;

  always_comb begin
    changed    = ctrl.a != a_prev_r;
    count_edge = ctrl.evt && changed && !(rise_only && !ctrl.a);
    up         = (ctrl.a == ctrl.b) ^ neg;

    acc_upd = acc_r;
    if (count_edge) begin
      if (up) begin
        if (acc_r != qdec_pkg::ACC_MAX) acc_upd = acc_r + 32'sd1;
      end else begin
        if (acc_r != qdec_pkg::ACC_MIN) acc_upd = acc_r - 32'sd1;
      end
    end

    events_nxt  = events_r + (qdec_pkg::CNT_W)'(ctrl.evt);
    ignored_nxt = ignored_r + (qdec_pkg::CNT_W)'(ctrl.evt && !changed);
    a_prev_nxt  = ctrl.evt ? ctrl.a : a_prev_r;

    if (ctrl.restart) begin
      acc_upd     = '0;
      events_nxt  = '0;
      ignored_nxt = '0;
      a_prev_nxt  = ctrl.a;
    end

    acc_nxt = (ctrl.take && !ctrl.restart) ? '0 : acc_upd;

    if (acc_upd > qdec_pkg::DELTA_MAX) begin
      delta = qdec_pkg::DELTA_MAX[qdec_pkg::DELTA_W-1:0];
    end else if (acc_upd < qdec_pkg::DELTA_MIN) begin
      delta = qdec_pkg::DELTA_MIN[qdec_pkg::DELTA_W-1:0];
    end else begin
      delta = acc_upd[qdec_pkg::DELTA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      events_r  <= '0;
      ignored_r <= '0;
      a_prev_r  <= 1'b0;
    end else if (commit) begin
      acc_r     <= acc_nxt;
      events_r  <= events_nxt;
      ignored_r <= ignored_nxt;
      a_prev_r  <= a_prev_nxt;
    end
  end

endmodule

### src/dual_quadrature_edge_counter_unit.sv
// ----------------------------------------------------------------------------
// dual_quadrature_edge_counter_unit
// pipeline: input transaction -> input register -> result register; throughput:
// one transaction per cycle unless out_stall holds a valid result, which raises
// in_stall
// reset: clears valids, accumulators, counters and stored A levels; signs = +1,
// rise_only = 1
// ----------------------------------------------------------------------------
module dual_quadrature_edge_counter_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic        [qdec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [qdec_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_left_edge_event,
  input  logic                                   in_right_edge_event,
  input  logic                                   in_left_a,
  input  logic                                   in_left_b,
  input  logic                                   in_right_a,
  input  logic                                   in_right_b,
  input  logic                                   in_take_left,
  input  logic                                   in_take_right,
  input  logic                                   in_clear_all,
  input  logic                                   in_restart,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qdec_pkg::DELTA_W-1:0]    out_left_delta,
  output logic signed [qdec_pkg::DELTA_W-1:0]    out_right_delta,
  output logic        [qdec_pkg::CNT_W-1:0]      out_left_events,
  output logic        [qdec_pkg::CNT_W-1:0]      out_left_ignored,
  output logic        [qdec_pkg::CNT_W-1:0]      out_right_events,
  output logic        [qdec_pkg::CNT_W-1:0]      out_right_ignored
);

  logic                 left_neg_r, right_neg_r, rise_only_r;
  logic                 s1_valid_r, out_valid_r, advance;
  qdec_pkg::side_ctrl_t left_ctrl_r, right_ctrl_r;

  logic signed [qdec_pkg::DELTA_W-1:0] left_delta, right_delta;
  logic        [qdec_pkg::CNT_W-1:0]   left_events, left_ignored;
  logic        [qdec_pkg::CNT_W-1:0]   right_events, right_ignored;

  logic signed [qdec_pkg::DELTA_W-1:0] left_delta_r, right_delta_r;
  logic        [qdec_pkg::CNT_W-1:0]   left_events_r, left_ignored_r;
  logic        [qdec_pkg::CNT_W-1:0]   right_events_r, right_ignored_r;

  // config registers, only the sign bit of a sign register matters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_neg_r  <= 1'b0;
      right_neg_r <= 1'b0;
      rise_only_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qdec_pkg::REG_LEFT_SIGN:  left_neg_r  <= cfg_data[qdec_pkg::SIGN_W-1];
        qdec_pkg::REG_RIGHT_SIGN: right_neg_r <= cfg_data[qdec_pkg::SIGN_W-1];
        qdec_pkg::REG_RISE_ONLY:  rise_only_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      left_ctrl_r  <= '{evt: in_left_edge_event, a: in_left_a, b: in_left_b,
                        take: in_take_left || in_clear_all, restart: in_restart};
      right_ctrl_r <= '{evt: in_right_edge_event, a: in_right_a, b: in_right_b,
                        take: in_take_right || in_clear_all, restart: in_restart};
    end
  end

  qdec_side u_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (s1_valid_r && advance),
    .ctrl        (left_ctrl_r),
    .neg         (left_neg_r),
    .rise_only   (rise_only_r),
    .delta       (left_delta),
    .events_nxt  (left_events),
    .ignored_nxt (left_ignored)
  );

  qdec_side u_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (s1_valid_r && advance),
    .ctrl        (right_ctrl_r),
    .neg         (right_neg_r),
    .rise_only   (rise_only_r),
    .delta       (right_delta),
    .events_nxt  (right_events),
    .ignored_nxt (right_ignored)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      left_delta_r    <= left_delta;
      right_delta_r   <= right_delta;
      left_events_r   <= left_events;
      left_ignored_r  <= left_ignored;
      right_events_r  <= right_events;
      right_ignored_r <= right_ignored;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_delta    = left_delta_r;
  assign out_right_delta   = right_delta_r;
  assign out_left_events   = left_events_r;
  assign out_left_ignored  = left_ignored_r;
  assign out_right_events  = right_events_r;
  assign out_right_ignored = right_ignored_r;

endmodule
